@@ sv/rx_byte_buffer_with_waiter_queue_macros.svh @@
`ifndef RX_BYTE_BUFFER_WITH_WAITER_QUEUE_MACROS_SVH
`define RX_BYTE_BUFFER_WITH_WAITER_QUEUE_MACROS_SVH

// checked only outside reset
`define RXBWQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every edge, reset included
`define RXBWQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ sv/rxbwq_pkg.sv @@
`default_nettype none

package rxbwq_pkg;

   localparam int DATA_DEPTH   = 512;
   localparam int WAITER_DEPTH = 128;

   localparam int DATA_AW    = $clog2(DATA_DEPTH);
   localparam int DATA_CW    = $clog2(DATA_DEPTH + 1);
   localparam int WAITER_AW  = $clog2(WAITER_DEPTH);
   localparam int WAITER_CW  = $clog2(WAITER_DEPTH + 1);

   localparam int BYTE_W = 8;
   localparam int ID_W   = 8;

   typedef enum logic [0:0] {
      FUNC_BYTE    = 1'b0,
      FUNC_REQUEST = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_BUFFERED  = 3'd0,
      ST_DELIVERED = 3'd1,
      ST_QUEUED    = 3'd2,
      ST_DROPPED   = 3'd3,
      ST_REJECTED  = 3'd4
   } status_type;

endpackage

`default_nettype wire

@@ sv/rxbwq_req_if.sv @@
`default_nettype none

interface rxbwq_req_if import rxbwq_pkg::*; ();

   logic              valid;
   logic              ready;
   logic              func;
   logic [BYTE_W-1:0] data_byte;
   logic [ID_W-1:0]   requester_id;

   modport source (output valid, output func, output data_byte, output requester_id,
                   input ready);
   modport sink   (input valid, input func, input data_byte, input requester_id,
                   output ready);

endinterface

`default_nettype wire

@@ sv/rxbwq_rsp_if.sv @@
`default_nettype none

interface rxbwq_rsp_if import rxbwq_pkg::*; ();

   logic              valid;
   logic              ready;
   status_type        status;
   logic [ID_W-1:0]   target_id;
   logic [BYTE_W-1:0] out_byte;

   modport source (output valid, output status, output target_id, output out_byte,
                   input ready);
   modport sink   (input valid, input status, input target_id, input out_byte,
                   output ready);

endinterface

`default_nettype wire

@@ sv/rxbwq_ram.sv @@
`default_nettype none

module rxbwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/rx_byte_buffer_with_waiter_queue.sv @@
// channel  | dir | interface     | payload
// ---------+-----+---------------+----------------------------------
// req_if   | in  | rxbwq_req_if  | func, data_byte, requester_id
// rsp_if   | out | rxbwq_rsp_if  | status, target_id, out_byte
//
// one result per item; an item can be taken every cycle unless a stalled result fills both stages
// a transfer reaches result valid through the fifo ram read and stage s1, then the result register
// both fifo rams have a registered read port, which sets the extra stage
// reset (synchronous, active high) empties both fifos; ram contents are not cleared
// a stalled result holds both stages; req_if.ready drops only when both are full

`default_nettype none

`include "rx_byte_buffer_with_waiter_queue_macros.svh"

module rx_byte_buffer_with_waiter_queue import rxbwq_pkg::*; (
   input wire logic     clock,
   input wire logic     reset,
   rxbwq_req_if.sink    req_if,
   rxbwq_rsp_if.source  rsp_if
);

   logic                 accept;
   logic                 s1_advance;
   logic                 out_free;

   logic [DATA_AW-1:0]   data_rd_ptr_ff, data_rd_ptr_in;
   logic [DATA_AW-1:0]   data_wr_ptr_ff, data_wr_ptr_in;
   logic [DATA_CW-1:0]   data_count_ff, data_count_in;
   logic [WAITER_AW-1:0] waiter_rd_ptr_ff, waiter_rd_ptr_in;
   logic [WAITER_AW-1:0] waiter_wr_ptr_ff, waiter_wr_ptr_in;
   logic [WAITER_CW-1:0] waiter_count_ff, waiter_count_in;

   logic                 data_wr_en, data_rd_en;
   logic                 waiter_wr_en, waiter_rd_en;
   logic [BYTE_W-1:0]    data_rd_data;
   logic [ID_W-1:0]      waiter_rd_data;

   status_type           dec_status;
   logic [ID_W-1:0]      dec_id;
   logic [BYTE_W-1:0]    dec_byte;

   logic                 s1_valid_ff, s1_valid_in;
   status_type           s1_status_ff;
   logic [ID_W-1:0]      s1_id_ff;
   logic [BYTE_W-1:0]    s1_byte_ff;
   logic                 s1_from_data_ff;
   logic                 s1_from_waiter_ff;

   logic                 out_valid_ff, out_valid_in;
   status_type           out_status_ff;
   logic [ID_W-1:0]      out_id_ff;
   logic [BYTE_W-1:0]    out_byte_ff;

   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign s1_advance   = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign accept       = req_if.valid && req_if.ready;

   // decode one item against the current fifo fill
   always_comb begin
      dec_status   = ST_BUFFERED;
      dec_id       = '0;
      dec_byte     = '0;
      data_wr_en   = 1'b0;
      data_rd_en   = 1'b0;
      waiter_wr_en = 1'b0;
      waiter_rd_en = 1'b0;
      if (req_if.func == FUNC_BYTE) begin
         if (waiter_count_ff != '0) begin
            dec_status   = ST_DELIVERED;
            dec_byte     = req_if.data_byte;
            waiter_rd_en = accept;
         end else if (data_count_ff == DATA_CW'(DATA_DEPTH)) begin
            dec_status = ST_DROPPED;
         end else begin
            dec_status = ST_BUFFERED;
            data_wr_en = accept;
         end
      end else begin
         if (data_count_ff != '0) begin
            dec_status = ST_DELIVERED;
            dec_id     = req_if.requester_id;
            data_rd_en = accept;
         end else if (waiter_count_ff == WAITER_CW'(WAITER_DEPTH)) begin
            dec_status = ST_REJECTED;
         end else begin
            dec_status   = ST_QUEUED;
            waiter_wr_en = accept;
         end
      end
   end

   // pointer and fill bookkeeping
   always_comb begin
      data_rd_ptr_in   = data_rd_ptr_ff;
      data_wr_ptr_in   = data_wr_ptr_ff;
      data_count_in    = data_count_ff;
      waiter_rd_ptr_in = waiter_rd_ptr_ff;
      waiter_wr_ptr_in = waiter_wr_ptr_ff;
      waiter_count_in  = waiter_count_ff;
      if (data_wr_en) begin
         data_wr_ptr_in = (data_wr_ptr_ff == DATA_AW'(DATA_DEPTH - 1)) ? '0
                          : data_wr_ptr_ff + DATA_AW'(1);
         data_count_in  = data_count_ff + DATA_CW'(1);
      end
      if (data_rd_en) begin
         data_rd_ptr_in = (data_rd_ptr_ff == DATA_AW'(DATA_DEPTH - 1)) ? '0
                          : data_rd_ptr_ff + DATA_AW'(1);
         data_count_in  = data_count_ff - DATA_CW'(1);
      end
      if (waiter_wr_en) begin
         waiter_wr_ptr_in = (waiter_wr_ptr_ff == WAITER_AW'(WAITER_DEPTH - 1)) ? '0
                            : waiter_wr_ptr_ff + WAITER_AW'(1);
         waiter_count_in  = waiter_count_ff + WAITER_CW'(1);
      end
      if (waiter_rd_en) begin
         waiter_rd_ptr_in = (waiter_rd_ptr_ff == WAITER_AW'(WAITER_DEPTH - 1)) ? '0
                            : waiter_rd_ptr_ff + WAITER_AW'(1);
         waiter_count_in  = waiter_count_ff - WAITER_CW'(1);
      end
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !out_free);
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         data_rd_ptr_ff   <= '0;
         data_wr_ptr_ff   <= '0;
         data_count_ff    <= '0;
         waiter_rd_ptr_ff <= '0;
         waiter_wr_ptr_ff <= '0;
         waiter_count_ff  <= '0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         data_rd_ptr_ff   <= data_rd_ptr_in;
         data_wr_ptr_ff   <= data_wr_ptr_in;
         data_count_ff    <= data_count_in;
         waiter_rd_ptr_ff <= waiter_rd_ptr_in;
         waiter_wr_ptr_ff <= waiter_wr_ptr_in;
         waiter_count_ff  <= waiter_count_in;
         s1_valid_ff      <= s1_valid_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff      <= dec_status;
         s1_id_ff          <= dec_id;
         s1_byte_ff        <= dec_byte;
         s1_from_data_ff   <= data_rd_en;
         s1_from_waiter_ff <= waiter_rd_en;
      end
      if (s1_advance) begin
         out_status_ff <= s1_status_ff;
         out_id_ff     <= s1_from_waiter_ff ? waiter_rd_data : s1_id_ff;
         out_byte_ff   <= s1_from_data_ff ? data_rd_data : s1_byte_ff;
      end
   end

   rxbwq_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DATA_DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (data_wr_ptr_ff),
      .wr_data (req_if.data_byte),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_ptr_ff),
      .rd_data (data_rd_data)
   );

   rxbwq_ram #(
      .WIDTH (ID_W),
      .DEPTH (WAITER_DEPTH)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (waiter_wr_en),
      .wr_addr (waiter_wr_ptr_ff),
      .wr_data (req_if.requester_id),
      .rd_en   (waiter_rd_en),
      .rd_addr (waiter_rd_ptr_ff),
      .rd_data (waiter_rd_data)
   );

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.status    = out_status_ff;
   assign rsp_if.target_id = out_id_ff;
   assign rsp_if.out_byte  = out_byte_ff;

   `RXBWQ_ASSERT(a_fifos_exclusive, !(data_count_ff != '0 && waiter_count_ff != '0), "data and waiter fifos both hold entries")
   `RXBWQ_ASSERT(a_data_fill_bound, data_count_ff <= DATA_CW'(DATA_DEPTH), "data fifo fill beyond depth")
   `RXBWQ_ASSERT(a_waiter_fill_bound, waiter_count_ff <= WAITER_CW'(WAITER_DEPTH), "waiter fifo fill beyond depth")
   `RXBWQ_ASSERT(a_fill_only_on_transfer, !accept |=> ($stable(data_count_ff) && $stable(waiter_count_ff)), "fifo fill changed without a transfer")
   `RXBWQ_ASSERT(a_no_overwrite_stage, accept |-> (!s1_valid_ff || s1_advance), "transfer into a held stage")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import rxbwq_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   target_id;
      logic [BYTE_W-1:0] out_byte;
   } rsp_type;

   logic clock;
   logic reset;

   rxbwq_req_if req_if ();
   rxbwq_rsp_if rsp_if ();

   rx_byte_buffer_with_waiter_queue i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // predicted fifo state
   logic [BYTE_W-1:0]    byte_ram [DATA_DEPTH];
   logic [DATA_AW-1:0]   byte_rd;
   logic [DATA_AW-1:0]   byte_wr;
   logic [DATA_CW-1:0]   byte_cnt;
   logic [ID_W-1:0]      waiter_ram [WAITER_DEPTH];
   logic [WAITER_AW-1:0] waiter_rd;
   logic [WAITER_AW-1:0] waiter_wr;
   logic [WAITER_CW-1:0] waiter_cnt;

   rsp_type awaited_rsp [$];
   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   send_idle_pct;
   int   recv_idle_pct;
   logic hold_active;
   event hold_go;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type resolve_item(func_type f, logic [BYTE_W-1:0] b,
                                            logic [ID_W-1:0] id);
      rsp_type r;
      r.status    = ST_BUFFERED;
      r.target_id = '0;
      r.out_byte  = '0;
      if (f == FUNC_BYTE) begin
         if (waiter_cnt != 0) begin
            r.status    = ST_DELIVERED;
            r.target_id = waiter_ram[waiter_rd];
            r.out_byte  = b;
            waiter_rd   = waiter_rd + 1'b1;
            waiter_cnt  = waiter_cnt - 1'b1;
         end else if (byte_cnt == DATA_DEPTH) begin
            r.status = ST_DROPPED;
         end else begin
            byte_ram[byte_wr] = b;
            byte_wr  = byte_wr + 1'b1;
            byte_cnt = byte_cnt + 1'b1;
         end
      end else begin
         if (byte_cnt != 0) begin
            r.status    = ST_DELIVERED;
            r.target_id = id;
            r.out_byte  = byte_ram[byte_rd];
            byte_rd     = byte_rd + 1'b1;
            byte_cnt    = byte_cnt - 1'b1;
         end else if (waiter_cnt == WAITER_DEPTH) begin
            r.status = ST_REJECTED;
         end else begin
            r.status = ST_QUEUED;
            waiter_ram[waiter_wr] = id;
            waiter_wr  = waiter_wr + 1'b1;
            waiter_cnt = waiter_cnt + 1'b1;
         end
      end
      return r;
   endfunction

   task automatic send_item(func_type f, logic [BYTE_W-1:0] b, logic [ID_W-1:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.func         <= f;
      req_if.data_byte    <= b;
      req_if.requester_id <= id;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      awaited_rsp.push_back(resolve_item(f, b, id));
   endtask

   task automatic send_random(func_type f);
      send_item(f, 8'($urandom), 8'($urandom));
   endtask

   // receiver side: stalls, hold-off and result checks
   always @(posedge clock) begin
      rsp_type exp_rsp;
      rsp_if.ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("unexpected result: status %0d target_id %0d out_byte %0d",
                   rsp_if.status, rsp_if.target_id, rsp_if.out_byte);
            mismatch_count++;
         end else begin
            exp_rsp = awaited_rsp.pop_front();
            if (rsp_if.status !== exp_rsp.status) begin
               $error("status: expected %0d actual %0d", exp_rsp.status, rsp_if.status);
               mismatch_count++;
            end
            if (rsp_if.target_id !== exp_rsp.target_id) begin
               $error("target_id: expected %0d actual %0d",
                      exp_rsp.target_id, rsp_if.target_id);
               mismatch_count++;
            end
            if (rsp_if.out_byte !== exp_rsp.out_byte) begin
               $error("out_byte: expected %0d actual %0d",
                      exp_rsp.out_byte, rsp_if.out_byte);
               mismatch_count++;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   initial begin
      hold_active <= 1'b0;
      forever begin
         @(hold_go);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(FUNC_REQUEST, 8'h00, 8'h00);
      send_item(FUNC_REQUEST, 8'hff, 8'hff);
      send_item(FUNC_BYTE, 8'ha5, 8'h3c);
      send_item(FUNC_BYTE, 8'h00, 8'hff);
      send_item(FUNC_BYTE, 8'hff, 8'h00);
      send_item(FUNC_BYTE, 8'h00, 8'hff);
      send_item(FUNC_BYTE, 8'h80, 8'h01);
      send_item(FUNC_REQUEST, 8'hff, 8'h5a);
      send_item(FUNC_REQUEST, 8'h00, 8'h01);
      send_item(FUNC_REQUEST, 8'h7f, 8'h80);
      send_item(FUNC_REQUEST, 8'h12, 8'h7f);
      send_item(FUNC_BYTE, 8'h01, 8'h00);
      send_item(FUNC_BYTE, 8'hfe, 8'hff);
      send_item(FUNC_REQUEST, 8'h55, 8'haa);
   endtask

   // fill the waiter fifo past its depth, then serve every waiter
   task automatic test_waiter_full();
      repeat (WAITER_DEPTH + 3) send_random(FUNC_REQUEST);
      repeat (WAITER_DEPTH + 2) send_random(FUNC_BYTE);
      repeat (2) send_random(FUNC_REQUEST);
   endtask

   // fill the data fifo past its depth, then deliver forty buffered bytes to requests
   task automatic test_data_full();
      repeat (DATA_DEPTH + 3) send_random(FUNC_BYTE);
      repeat (40) send_random(FUNC_REQUEST);
   endtask

   // receiver holds off while items keep coming, so the input stalls
   task automatic test_backpressure();
      -> hold_go;
      repeat (30) send_random($urandom_range(1) ? FUNC_REQUEST : FUNC_BYTE);
   endtask

   task automatic test_random_traffic(int n_items);
      int req_pct;
      req_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(2))
               0: req_pct = 20;
               1: req_pct = 50;
               default: req_pct = 85;
            endcase
         end
         send_random(($urandom_range(99) < req_pct) ? FUNC_REQUEST : FUNC_BYTE);
      end
   endtask

   initial begin
      int wait_cycles;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.func         <= FUNC_BYTE;
      req_if.data_byte    <= '0;
      req_if.requester_id <= '0;
      byte_rd    = '0;
      byte_wr    = '0;
      byte_cnt   = '0;
      waiter_rd  = '0;
      waiter_wr  = '0;
      waiter_cnt = '0;
      send_idle_pct = 35;
      recv_idle_pct = 53;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_waiter_full();
      test_random_traffic(100);
      send_idle_pct = 53;
      recv_idle_pct = 35;
      test_data_full();
      test_random_traffic(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_traffic(120);

      req_if.valid <= 1'b0;
      wait_cycles = 0;
      while (awaited_rsp.size() != 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (awaited_rsp.size() != 0)
            $error("%0d results never arrived", awaited_rsp.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
